[rtl/core/tcprb_pkg.sv]
// ----------------------------------------------------------------------------
// tcprb_pkg
// Shared constants, types and helpers of the retransmit ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcprb_pkg;

  localparam int RING_DEPTH = 1024;
  localparam int MAX_BURST  = 64;

  localparam int PTR_W   = $clog2(RING_DEPTH);
  localparam int CNT_W   = $clog2(RING_DEPTH + 1);
  localparam int N_W     = $clog2(MAX_BURST + 1);
  localparam int SUM_W   = PTR_W + 1;
  localparam int DATA_W  = 8;
  localparam int FUNC_W  = 2;
  localparam int COUNT_W = 7;

  localparam int JQ_DEPTH = 4;
  localparam int OQ_DEPTH = 4;

  typedef enum logic [FUNC_W-1:0] {
    FN_WRITE = 2'd0,
    FN_READ  = 2'd1,
    FN_SEND  = 2'd2,
    FN_ACK   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_WRITE,
    JOB_READ
  } job_kind_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [PTR_W-1:0]  addr;
    logic [DATA_W-1:0] data;
    logic [N_W-1:0]    n;
    logic              acc;
    logic [CNT_W-1:0]  free_cnt;
    logic [CNT_W-1:0]  wait_cnt;
  } job_t;

  // p + k modulo the ring depth, k at most the ring depth
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] k);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(p) + SUM_W'(k);
    if (sum >= SUM_W'(RING_DEPTH)) begin
      sum = sum - SUM_W'(RING_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/tcp_retransmit_ring_buffer.sv]
// ----------------------------------------------------------------------------
// tcp_retransmit_ring_buffer
// Byte ring with write, send and release pointers for TCP retransmission.
// ----------------------------------------------------------------------------
//  channel  | ports                                         | transfer when
//  ---------+-----------------------------------------------+-------------------
//  input    | in_func, in_data_byte, in_count               | in_push & !in_full
//  result   | out_valid_res, out_out_byte, out_last,        | out_pop & !out_empty
//           | out_accepted, out_free_count, out_waiting_count|
//
// Write and acknowledge each yield one result; read and send move one byte per
// cycle while the result queue has room (one result if nothing moves), as the
// byte store has a single port. Results pass job queue, s1 and result queue.
// Reset clears pointers and counts at once; the store is not cleared.
// Inputs are taken while the 4-entry job queue has room; the store stops
// issuing when the 4-entry result queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_retransmit_ring_buffer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire logic [tcprb_pkg::FUNC_W-1:0]   in_func,
  input  wire logic [tcprb_pkg::DATA_W-1:0]   in_data_byte,
  input  wire logic [tcprb_pkg::COUNT_W-1:0]  in_count,
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output logic                                out_valid_res,
  output logic [tcprb_pkg::DATA_W-1:0]        out_out_byte,
  output logic                                out_last,
  output logic                                out_accepted,
  output logic [tcprb_pkg::CNT_W-1:0]         out_free_count,
  output logic [tcprb_pkg::CNT_W-1:0]         out_waiting_count
);

  tcprb_pkg::job_t new_job, head_job;
  logic            in_accept;
  logic            jq_empty, job_pop;

  assign in_accept = in_push && !in_full;

  tcprb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .func      (in_func),
    .data_byte (in_data_byte),
    .count     (in_count),
    .job       (new_job)
  );

  tcprb_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_accept),
    .push_job (new_job),
    .full     (in_full),
    .pop      (job_pop),
    .head_job (head_job),
    .empty    (jq_empty)
  );

  tcprb_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_job          (head_job),
    .job_valid         (!jq_empty),
    .job_pop           (job_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_valid_res     (out_valid_res),
    .out_byte          (out_out_byte),
    .out_last          (out_last),
    .out_accepted      (out_accepted),
    .out_free_count    (out_free_count),
    .out_waiting_count (out_waiting_count)
  );

endmodule

`default_nettype wire

[rtl/core/tcprb_ram.sv]
// ----------------------------------------------------------------------------
// tcprb_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcprb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/tcprb_jobq.sv]
// ----------------------------------------------------------------------------
// tcprb_jobq
// Small FIFO of decoded jobs between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tcprb_jobq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire tcprb_pkg::job_t push_job,
  output logic                 full,
  input  wire logic            pop,
  output tcprb_pkg::job_t      head_job,
  output logic                 empty
);

  localparam int AW = $clog2(tcprb_pkg::JQ_DEPTH);
  localparam int CW = $clog2(tcprb_pkg::JQ_DEPTH + 1);

  tcprb_pkg::job_t q_r [tcprb_pkg::JQ_DEPTH];
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [AW-1:0]   rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full     = (cnt_r == CW'(tcprb_pkg::JQ_DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_job = q_r[rp_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (32'(wp_r) == tcprb_pkg::JQ_DEPTH - 1) ? '0 : wp_r + AW'(1);
    end
    if (do_pop) begin
      rp_nxt = (32'(rp_r) == tcprb_pkg::JQ_DEPTH - 1) ? '0 : rp_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= push_job;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= tcprb_pkg::JQ_DEPTH)
    else $error("job queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) || (cnt_r == CW'(tcprb_pkg::JQ_DEPTH)) |-> wp_r == rp_r)
    else $error("job queue pointers disagree with count");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("job queue count missed a push");

endmodule

`default_nettype wire

[rtl/core/tcprb_front.sv]
// ----------------------------------------------------------------------------
// tcprb_front
// Accepts items, clamps counts, advances the ring pointers and issues jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module tcprb_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            accept,
  input  wire logic [tcprb_pkg::FUNC_W-1:0]    func,
  input  wire logic [tcprb_pkg::DATA_W-1:0]    data_byte,
  input  wire logic [tcprb_pkg::COUNT_W-1:0]   count,
  output tcprb_pkg::job_t                      job
);

  localparam int PW = tcprb_pkg::PTR_W;
  localparam int CW = tcprb_pkg::CNT_W;
  localparam int NW = tcprb_pkg::N_W;

  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rel_ptr_r, rel_ptr_nxt;
  logic [PW-1:0] snd_ptr_r, snd_ptr_nxt;
  logic [CW-1:0] stored_r, stored_nxt;
  logic [CW-1:0] unacked_r, unacked_nxt;
  logic [CW-1:0] waiting;
  logic [CW-1:0] n_c;
  logic [CW-1:0] from_unacked;
  logic [NW-1:0] req;

  assign waiting = stored_r - unacked_r;

  always_comb begin
    req = (32'(count) > tcprb_pkg::MAX_BURST) ? NW'(tcprb_pkg::MAX_BURST) : NW'(count);
    wr_ptr_nxt   = wr_ptr_r;
    rel_ptr_nxt  = rel_ptr_r;
    snd_ptr_nxt  = snd_ptr_r;
    stored_nxt   = stored_r;
    unacked_nxt  = unacked_r;
    n_c          = '0;
    from_unacked = '0;
    job.kind     = tcprb_pkg::JOB_NONE;
    job.addr     = wr_ptr_r;
    job.data     = data_byte;
    job.acc      = 1'b0;
    unique case (tcprb_pkg::func_t'(func))
      tcprb_pkg::FN_WRITE: begin
        job.addr = wr_ptr_r;
        if (32'(stored_r) < tcprb_pkg::RING_DEPTH) begin
          job.acc    = 1'b1;
          job.kind   = tcprb_pkg::JOB_WRITE;
          wr_ptr_nxt = tcprb_pkg::ptr_add(wr_ptr_r, CW'(1));
          stored_nxt = stored_r + CW'(1);
        end
      end
      tcprb_pkg::FN_READ: begin
        job.addr     = rel_ptr_r;
        n_c          = (32'(req) < 32'(stored_r)) ? CW'(req) : stored_r;
        from_unacked = (n_c < unacked_r) ? n_c : unacked_r;
        rel_ptr_nxt  = tcprb_pkg::ptr_add(rel_ptr_r, n_c);
        stored_nxt   = stored_r - n_c;
        unacked_nxt  = unacked_r - from_unacked;
        if (n_c > from_unacked) begin
          snd_ptr_nxt = rel_ptr_nxt;
        end
        job.acc  = (n_c != '0);
        job.kind = (n_c != '0) ? tcprb_pkg::JOB_READ : tcprb_pkg::JOB_NONE;
      end
      tcprb_pkg::FN_SEND: begin
        job.addr    = snd_ptr_r;
        n_c         = (32'(req) < 32'(waiting)) ? CW'(req) : waiting;
        snd_ptr_nxt = tcprb_pkg::ptr_add(snd_ptr_r, n_c);
        unacked_nxt = unacked_r + n_c;
        job.acc     = (n_c != '0);
        job.kind    = (n_c != '0) ? tcprb_pkg::JOB_READ : tcprb_pkg::JOB_NONE;
      end
      tcprb_pkg::FN_ACK: begin
        n_c         = (32'(count) < 32'(unacked_r)) ? CW'(count) : unacked_r;
        rel_ptr_nxt = tcprb_pkg::ptr_add(rel_ptr_r, n_c);
        stored_nxt  = stored_r - n_c;
        unacked_nxt = unacked_r - n_c;
        job.acc     = (n_c != '0);
      end
      default: begin
        job.kind = tcprb_pkg::JOB_NONE;
      end
    endcase
    job.n        = (job.kind == tcprb_pkg::JOB_READ) ? NW'(n_c) : NW'(0);
    job.free_cnt = CW'(tcprb_pkg::RING_DEPTH) - stored_nxt;
    job.wait_cnt = stored_nxt - unacked_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rel_ptr_r <= '0;
      snd_ptr_r <= '0;
      stored_r  <= '0;
      unacked_r <= '0;
    end else if (accept) begin
      wr_ptr_r  <= wr_ptr_nxt;
      rel_ptr_r <= rel_ptr_nxt;
      snd_ptr_r <= snd_ptr_nxt;
      stored_r  <= stored_nxt;
      unacked_r <= unacked_nxt;
    end
  end

  a_stored_max: assert property (@(posedge clk) disable iff (!rst_n)
    32'(stored_r) <= tcprb_pkg::RING_DEPTH)
    else $error("stored count beyond ring depth");

  a_unacked_le: assert property (@(posedge clk) disable iff (!rst_n)
    unacked_r <= stored_r)
    else $error("unacked count beyond stored count");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (tcprb_pkg::func_t'(func) == tcprb_pkg::FN_WRITE) &&
    (32'(stored_r) == tcprb_pkg::RING_DEPTH) |=> $stable(stored_r) && $stable(wr_ptr_r))
    else $error("write into full ring changed state");

endmodule

`default_nettype wire

[rtl/core/tcprb_back.sv]
// ----------------------------------------------------------------------------
// tcprb_back
// Runs jobs into a result queue, one store access per cycle while it has room.
// ----------------------------------------------------------------------------
`default_nettype none

module tcprb_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tcprb_pkg::job_t               head_job,
  input  wire logic                          job_valid,
  output logic                               job_pop,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic                               out_valid_res,
  output logic [tcprb_pkg::DATA_W-1:0]       out_byte,
  output logic                               out_last,
  output logic                               out_accepted,
  output logic [tcprb_pkg::CNT_W-1:0]        out_free_count,
  output logic [tcprb_pkg::CNT_W-1:0]        out_waiting_count
);

  localparam int PW = tcprb_pkg::PTR_W;
  localparam int CW = tcprb_pkg::CNT_W;
  localparam int NW = tcprb_pkg::N_W;
  localparam int AW = $clog2(tcprb_pkg::OQ_DEPTH);
  localparam int QW = $clog2(tcprb_pkg::OQ_DEPTH + 1);

  typedef struct packed {
    logic                         valid_res;
    logic [tcprb_pkg::DATA_W-1:0] data;
    logic                         last;
    logic                         acc;
    logic [CW-1:0]                free_cnt;
    logic [CW-1:0]                wait_cnt;
  } res_t;

  logic [NW-1:0]                off_r, off_nxt;
  logic                         issue, is_rd, last_byte;
  logic                         ram_en, ram_we;
  logic [PW-1:0]                ram_addr;
  logic [tcprb_pkg::DATA_W-1:0] ram_rdata;

  logic          s1_valid_r;
  res_t          s1_r;
  res_t          oq_r [tcprb_pkg::OQ_DEPTH];
  res_t          oq_in, oq_head;
  logic [AW-1:0] oq_wp_r, oq_rp_r;
  logic [QW-1:0] oq_cnt_r, oq_cnt_nxt;
  logic          oq_pop;

  assign issue     = job_valid && (32'(oq_cnt_r) + 32'(s1_valid_r) < tcprb_pkg::OQ_DEPTH);
  assign is_rd     = (head_job.kind == tcprb_pkg::JOB_READ);
  assign last_byte = !is_rd || (32'(off_r) + 32'd1 == 32'(head_job.n));
  assign job_pop   = issue && last_byte;
  assign ram_en    = issue && (head_job.kind != tcprb_pkg::JOB_NONE);
  assign ram_we    = (head_job.kind == tcprb_pkg::JOB_WRITE);
  assign ram_addr  = is_rd ? tcprb_pkg::ptr_add(head_job.addr, CW'(off_r)) : head_job.addr;
  assign off_nxt   = last_byte ? '0 : off_r + NW'(1);

  tcprb_ram #(
    .WIDTH (tcprb_pkg::DATA_W),
    .DEPTH (tcprb_pkg::RING_DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (head_job.data),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue;
      if (issue) begin
        off_r <= off_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_r.valid_res <= is_rd;
      s1_r.data      <= '0;
      s1_r.last      <= last_byte;
      s1_r.acc       <= head_job.acc;
      s1_r.free_cnt  <= head_job.free_cnt;
      s1_r.wait_cnt  <= head_job.wait_cnt;
    end
  end

  always_comb begin
    oq_in      = s1_r;
    oq_in.data = s1_r.valid_res ? ram_rdata : '0;
  end

  // result queue
  assign oq_head    = oq_r[oq_rp_r];
  assign out_empty  = (oq_cnt_r == '0);
  assign oq_pop     = out_pop && !out_empty;

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (s1_valid_r && !oq_pop) begin
      oq_cnt_nxt = oq_cnt_r + QW'(1);
    end else if (oq_pop && !s1_valid_r) begin
      oq_cnt_nxt = oq_cnt_r - QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      oq_cnt_r <= oq_cnt_nxt;
      if (s1_valid_r) begin
        oq_wp_r <= (32'(oq_wp_r) == tcprb_pkg::OQ_DEPTH - 1) ? '0 : oq_wp_r + AW'(1);
      end
      if (oq_pop) begin
        oq_rp_r <= (32'(oq_rp_r) == tcprb_pkg::OQ_DEPTH - 1) ? '0 : oq_rp_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      oq_r[oq_wp_r] <= oq_in;
    end
  end

  assign out_valid_res     = oq_head.valid_res;
  assign out_byte          = oq_head.data;
  assign out_last          = oq_head.last;
  assign out_accepted      = oq_head.acc;
  assign out_free_count    = oq_head.free_cnt;
  assign out_waiting_count = oq_head.wait_cnt;

  a_oq_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> 32'(oq_cnt_r) < tcprb_pkg::OQ_DEPTH)
    else $error("result queue overflow");

  a_burst_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && is_rd |-> head_job.n != '0)
    else $error("empty burst reached back end");

  a_off_range: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && is_rd |-> off_r < head_job.n)
    else $error("burst offset past burst length");

  a_off_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> off_r == '0)
    else $error("burst offset not cleared after job");

endmodule

`default_nettype wire
